>>> src/pcpa_pkg.sv
// shared constants and types for the per-cpu page allocator
`default_nettype none
package pcpa_pkg;

  localparam int AddrW      = 40;
  localparam int PageShift  = 12;
  localparam int PfnW       = AddrW - PageShift;
  localparam int StealW     = 8;
  localparam int CpuFieldW  = 3;
  localparam int CfgIdxW    = 2;

  localparam int NumCpusDef  = 8;
  localparam int NumPagesDef = 32768;

  localparam logic [AddrW-1:0]  BaseAddrRst   = 40'h00_8000_0000;
  localparam logic [AddrW-1:0]  TopAddrRst    = 40'h00_8800_0000;
  localparam logic [StealW-1:0] StealCountRst = 8'd32;

  typedef enum logic [1:0] {
    STATUS_FREED   = 2'd0,
    STATUS_ALLOC   = 2'd1,
    STATUS_NOMEM   = 2'd2,
    STATUS_BADADDR = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_ADDR   = 2'd0,
    REG_TOP_ADDR    = 2'd1,
    REG_STEAL_COUNT = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_e;

endpackage
`default_nettype wire

>>> src/per_cpu_page_allocator_with_steal_top.sv
// per-cpu lifo page allocator with stealing from other cpus' free lists
//
// usage: a transaction on the input channel (valid/stall) carries func, cpu and
// page_addr; each one produces exactly one transaction on the output channel
// carrying status and alloc_addr. in_stall_o is high while a transaction is in
// work, so items are handled one at a time.
// sequencing: a free passes a bounds check, then the link write, and its result
// is registered with the write; an alloc from a non-empty local list reads the
// head and link store, then pops. the next transaction is taken only once the
// sequencer is back in idle. an alloc on an empty local list first walks the
// other cpus' lists, passing over each cpu and stealing up to steal_count pages
// (a link read, then an unlink and push per page), then pops, all through the
// single port pair of the link store.
// the output register holds a finished result while out_stall_i is high; the
// sequencer waits in its final state until the register is free.
// reset: all free lists are empty; config and control registers take reset values;
// the link store needs no clearing since a link is written before it is read.
// config writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) belong between transactions.
`default_nettype none
module per_cpu_page_allocator_with_steal_top #(
  parameter int NUM_CPUS  = pcpa_pkg::NumCpusDef,
  parameter int NUM_PAGES = pcpa_pkg::NumPagesDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pcpa_pkg::CfgIdxW-1:0]       cfg_addr_i,
  input  wire logic [pcpa_pkg::AddrW-1:0]         cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               func_i,
  input  wire logic [pcpa_pkg::CpuFieldW-1:0]     cpu_i,
  input  wire logic [pcpa_pkg::AddrW-1:0]         page_addr_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              status_o,
  output logic [pcpa_pkg::AddrW-1:0]              alloc_addr_o
);

  localparam int AW  = pcpa_pkg::AddrW;
  localparam int PS  = pcpa_pkg::PageShift;
  localparam int FW  = pcpa_pkg::PfnW;
  localparam int SW  = pcpa_pkg::StealW;
  localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int PW  = $clog2(NUM_PAGES);
  localparam logic [CW:0] CpuLimit  = (CW + 1)'(NUM_CPUS);
  localparam logic [FW-1:0] PageLimit = FW'(NUM_PAGES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK1  = 3'd1;
  localparam logic [2:0] S_CHK2  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_STEAL = 3'd5;
  localparam logic [2:0] S_POP   = 3'd6;

  typedef struct packed {
    logic          last;
    logic [PW-1:0] nxt;
  } link_t;

  // configuration
  logic [AW-1:0] base_q, top_q;
  logic [SW-1:0] steal_q;

  // captured transaction
  logic [CW-1:0]               cpu_q;
  logic                        cpu_ok_q;
  logic [AW-1:0]               pa_q;

  // sequencer
  logic [2:0]    state_q, state_d;
  logic          bad_q, bad_d;
  logic [FW-1:0] idx_q, idx_d;
  logic [PW-1:0] r_q, r_d;
  logic          rv_q, rv_d;
  logic [SW-1:0] left_q, left_d;
  logic [CW:0]   scan_q, scan_d;

  // list heads
  logic [PW-1:0] head_q [NUM_CPUS];
  logic          hvld_q [NUM_CPUS];
  logic [CW-1:0] hidx;
  logic [PW-1:0] head_rd;
  logic          hvld_rd;
  logic          head_we;
  logic [PW-1:0] head_wnxt;
  logic          head_wvld;

  // link store
  link_t         link_mem [NUM_PAGES];
  link_t         rd_q;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  link_t         mem_wdata;

  // result register
  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [AW-1:0] addr_q;
  logic          fin;
  logic [1:0]    fin_status;
  logic [AW-1:0] fin_addr;
  logic          out_free;

  logic          in_acc;
  logic          cpu_ok;
  logic [FW-1:0] pop_pfn;

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign alloc_addr_o = addr_q;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign cpu_ok       = ({2'b00, cpu_i} < 5'(NUM_CPUS));

  // during a steal walk the head port follows the scan index, else the requester
  assign hidx    = (state_q == S_SCAN || state_q == S_STEAL) ? scan_q[CW-1:0] : cpu_q;
  assign head_rd = head_q[hidx];
  assign hvld_rd = hvld_q[hidx];
  assign pop_pfn = base_q[AW-1:PS] + FW'(r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= pcpa_pkg::BaseAddrRst;
      top_q   <= pcpa_pkg::TopAddrRst;
      steal_q <= pcpa_pkg::StealCountRst;
    end else if (cfg_we_i) begin
      unique case (pcpa_pkg::cfg_reg_e'(cfg_addr_i))
        pcpa_pkg::REG_BASE_ADDR:   base_q  <= cfg_wdata_i;
        pcpa_pkg::REG_TOP_ADDR:    top_q   <= cfg_wdata_i;
        pcpa_pkg::REG_STEAL_COUNT: steal_q <= cfg_wdata_i[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    bad_d      = bad_q;
    idx_d      = idx_q;
    r_d        = r_q;
    rv_d       = rv_q;
    left_d     = left_q;
    scan_d     = scan_q;
    head_we    = 1'b0;
    head_wnxt  = head_rd;
    head_wvld  = hvld_rd;
    mem_we     = 1'b0;
    mem_waddr  = idx_q[PW-1:0];
    mem_wdata  = '{last: !hvld_rd, nxt: head_rd};
    rd_en      = 1'b0;
    rd_addr    = head_rd;
    fin        = 1'b0;
    fin_status = pcpa_pkg::STATUS_NOMEM;
    fin_addr   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = func_i ? S_ALLOC : S_CHK1;
        end
      end
      S_CHK1: begin
        bad_d   = !cpu_ok_q || (pa_q[PS-1:0] != '0) || (pa_q < base_q) || (pa_q >= top_q);
        idx_d   = pa_q[AW-1:PS] - base_q[AW-1:PS];
        state_d = S_CHK2;
      end
      S_CHK2: begin
        if (out_free) begin
          fin     = 1'b1;
          state_d = S_IDLE;
          if (bad_q || idx_q >= PageLimit) begin
            fin_status = pcpa_pkg::STATUS_BADADDR;
          end else begin
            fin_status = pcpa_pkg::STATUS_FREED;
            mem_we     = 1'b1;
            head_we    = 1'b1;
            head_wnxt  = idx_q[PW-1:0];
            head_wvld  = 1'b1;
          end
        end
      end
      S_ALLOC: begin
        if (!cpu_ok_q) begin
          if (out_free) begin
            fin     = 1'b1;
            state_d = S_IDLE;
          end
        end else if (hvld_rd) begin
          rd_en   = 1'b1;
          r_d     = head_rd;
          rv_d    = 1'b1;
          state_d = S_POP;
        end else begin
          rv_d    = 1'b0;
          left_d  = steal_q;
          scan_d  = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (left_q == '0 || scan_q == CpuLimit) begin
          if (rv_q) begin
            rd_en   = 1'b1;
            rd_addr = r_q;
            state_d = S_POP;
          end else if (out_free) begin
            // requester's list stays empty
            fin     = 1'b1;
            state_d = S_IDLE;
          end
        end else if (scan_q[CW-1:0] == cpu_q || !hvld_rd) begin
          scan_d = scan_q + 1'b1;
        end else begin
          rd_en   = 1'b1;
          state_d = S_STEAL;
        end
      end
      S_STEAL: begin
        // unlink the victim's head and push it on the temporary list
        head_we   = 1'b1;
        head_wnxt = rd_q.nxt;
        head_wvld = !rd_q.last;
        mem_we    = 1'b1;
        mem_waddr = head_rd;
        mem_wdata = '{last: !rv_q, nxt: r_q};
        r_d       = head_rd;
        rv_d      = 1'b1;
        left_d    = left_q - 1'b1;
        state_d   = S_SCAN;
      end
      S_POP: begin
        if (out_free) begin
          head_we    = 1'b1;
          head_wnxt  = rd_q.nxt;
          head_wvld  = !rd_q.last;
          fin        = 1'b1;
          fin_status = pcpa_pkg::STATUS_ALLOC;
          fin_addr   = {pop_pfn, {PS{1'b0}}};
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      left_q      <= '0;
      scan_q      <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      left_q  <= left_d;
      scan_q  <= scan_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q <= bad_d;
    idx_q <= idx_d;
    r_q   <= r_d;
    if (in_acc) begin
      cpu_q    <= CW'(cpu_i);
      cpu_ok_q <= cpu_ok;
      pa_q     <= page_addr_i;
    end
    if (fin) begin
      status_q <= fin_status;
      addr_q   <= fin_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        hvld_q[i] <= 1'b0;
      end
    end else if (head_we) begin
      hvld_q[hidx] <= head_wvld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_q[hidx] <= head_wnxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= link_mem[rd_addr];
    end
  end

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted transaction left the sequencer idle");

  a_pop_has_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> rv_q)
    else $error("pop without a page to hand out");

  a_steal_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STEAL |=> rv_q && state_q == S_SCAN)
    else $error("stolen page not taken onto temporary list");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_STEAL) |-> scan_q <= CpuLimit)
    else $error("steal scan index out of range");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != pcpa_pkg::STATUS_ALLOC) |-> addr_q == '0)
    else $error("address on a result that allocated nothing");

  a_fin_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> out_free)
    else $error("result finished over an untaken result");

endmodule
`default_nettype wire
